@@ sv/rs485ccs_pkg.sv @@
// Shared types and constants for the RS485 cell command slave.
// No dependencies; imported by every module of the block.
package rs485ccs_pkg;

	// Frame and reply byte codes
	localparam logic [7:0] NULL_BYTE  = 8'h00;
	localparam logic [7:0] START_BYTE = 8'h02;
	localparam logic [7:0] REPLY_HEAD = 8'h03;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_ONE  = 8'h31;
	localparam logic [7:0] ADDR_RADIX = 8'd10;

	// Frame position codes
	localparam logic [1:0] POS_IDLE = 2'd0;
	localparam logic [1:0] POS_DIG1 = 2'd1;
	localparam logic [1:0] POS_DIG2 = 2'd2;
	localparam logic [1:0] POS_CMD  = 2'd3;

	// Reply length and byte index width
	localparam int REPLY_LEN = 6;
	localparam int IDX_W     = $clog2(REPLY_LEN);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(REPLY_LEN - 1);

	// Reply queue sizing
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One pending reply: solenoid result, full-power start flag and the sampled sensors
	typedef struct packed {
		logic       solenoid;
		logic       start;
		logic [3:0] sensors;  // [0] sensor one .. [3] sensor four
	} reply_t;

	// Queue handshake toward either side
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

@@ sv/rs485_cell_command_slave.sv @@
// Top level of the RS485 cell command slave: frame parser, reply queue, serializer.
// Depends on rs485ccs_pkg, rs485ccs_front, rs485ccs_queue and rs485ccs_back.
//
//   Channel   Dir  Handshake             Content
//   s_*       in   s_tvalid / s_tready   received byte and sensor states
//   m_*       out  m_tvalid / m_tready   reply byte, last flag, solenoid flags
//   cfg_*     in   cfg_valid / cfg_ready cell address
//
// The front end takes one byte per cycle; a frame that closes with a valid
// address queues one reply request. The back end sends each reply as six
// bytes, one per cycle while m_tready is high. The input stalls only while
// the two-entry reply queue is full. Reset clears frame position, solenoid
// state, queue and serializer; no clearing pass. cfg_ready is always high.
module rs485_cell_command_slave (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_byte[7:0], sensor_one, sensor_two,
	                               // sensor_three, sensor_four, 4'b0
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // tx_byte[7:0]
	output logic        m_tlast,   // last_byte
	output logic [1:0]  m_tuser,   // solenoid_on, full_power_start
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // cell_address[7:0]
);
	import rs485ccs_pkg::*;

	logic       accept;
	logic       push;
	logic       pop;
	reply_t     push_data;
	reply_t     pop_data;
	qstat_t     stat;
	logic [7:0] cell_address_q;

	assign s_tready  = !stat.full;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Hold the configured cell address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_address_q <= '0;
		end else if (cfg_valid) begin
			cell_address_q <= cfg_data;
		end
	end

	rs485ccs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.rx_byte      (s_tdata[7:0]),
		.sensors      (s_tdata[11:8]),
		.cell_address (cell_address_q),
		.push         (push),
		.push_data    (push_data)
	);

	rs485ccs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (stat)
	);

	rs485ccs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.pop_data (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

@@ sv/rs485ccs_front.sv @@
// Front end: parses received bytes into frames, checks address, applies command.
// Depends on rs485ccs_pkg; pushes one reply request per answered frame.
module rs485ccs_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            rx_byte,
	input  logic [3:0]            sensors,
	input  logic [7:0]            cell_address,
	output logic                  push,
	output rs485ccs_pkg::reply_t  push_data
);
	import rs485ccs_pkg::*;

	logic [1:0] pos_q;
	logic [7:0] dig1_q;
	logic [7:0] dig2_q;
	logic       solenoid_q;

	logic [7:0] tens;
	logic [7:0] ones;
	logic [7:0] addr;
	logic       closing;
	logic       frame_ok;
	logic       sol_next;
	logic       start_next;

	// Decode address and command of the closing frame
	always_comb begin
		tens       = dig1_q - ASCII_ZERO;
		ones       = dig2_q - ASCII_ZERO;
		addr       = (tens << 3) + (tens << 1) + ones;
		closing    = accept && (rx_byte != NULL_BYTE) && (rx_byte != START_BYTE)
			&& (pos_q == POS_CMD);
		frame_ok   = (dig1_q >= ASCII_ZERO) && (dig2_q >= ASCII_ZERO)
			&& (rx_byte >= ASCII_ZERO) && (addr == cell_address);
		sol_next   = solenoid_q;
		start_next = 1'b0;
		if (rx_byte == ASCII_ONE) begin
			sol_next   = 1'b1;
			start_next = !solenoid_q;
		end else if (rx_byte == ASCII_ZERO) begin
			sol_next = 1'b0;
		end
	end

	assign push                = closing && frame_ok;
	assign push_data.solenoid  = sol_next;
	assign push_data.start     = start_next;
	assign push_data.sensors   = sensors;

	// Advance frame position and solenoid state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_IDLE;
			solenoid_q <= 1'b0;
		end else if (accept && rx_byte != NULL_BYTE) begin
			if (rx_byte == START_BYTE) begin
				pos_q <= POS_DIG1;
			end else begin
				case (pos_q)
					POS_DIG1: pos_q <= POS_DIG2;
					POS_DIG2: pos_q <= POS_CMD;
					POS_CMD: begin
						pos_q <= POS_IDLE;
						if (frame_ok) begin
							solenoid_q <= sol_next;
						end
					end
					default: pos_q <= POS_IDLE;
				endcase
			end
		end
	end

	// Capture address digits
	always_ff @(posedge clk) begin
		if (accept && rx_byte != NULL_BYTE && rx_byte != START_BYTE) begin
			if (pos_q == POS_DIG1) begin
				dig1_q <= rx_byte;
			end
			if (pos_q == POS_DIG2) begin
				dig2_q <= rx_byte;
			end
		end
	end

endmodule

@@ sv/rs485ccs_queue.sv @@
// Short FIFO of pending reply requests between front and back ends.
// Depends on rs485ccs_pkg for the entry type and depth.
module rs485ccs_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rs485ccs_pkg::reply_t  push_data,
	input  logic                  pop,
	output rs485ccs_pkg::reply_t  pop_data,
	output rs485ccs_pkg::qstat_t  stat
);
	import rs485ccs_pkg::*;

	reply_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];

	// Store request entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/rs485ccs_back.sv @@
// Back end: serializes each queued reply request into six reply bytes.
// Depends on rs485ccs_pkg; drives the master-side stream of the top level.
module rs485ccs_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rs485ccs_pkg::qstat_t        stat,
	input  rs485ccs_pkg::reply_t        pop_data,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,
	output logic                        m_tlast,
	output logic [1:0]                  m_tuser
);
	import rs485ccs_pkg::*;

	logic             active_q;
	logic [IDX_W-1:0] idx_q;
	reply_t           desc_q;
	logic             fire;
	logic             done;

	assign fire     = active_q && m_tready;
	assign done     = fire && (idx_q == IDX_LAST);
	assign pop      = !stat.empty && (!active_q || done);
	assign m_tvalid = active_q;
	assign m_tlast  = (idx_q == IDX_LAST);
	assign m_tuser  = {desc_q.start, desc_q.solenoid};

	// Select the reply byte for the current index
	always_comb begin
		case (idx_q)
			IDX_W'(0): m_tdata = REPLY_HEAD;
			IDX_W'(1): m_tdata = ASCII_ZERO + {7'd0, desc_q.solenoid};
			IDX_W'(2): m_tdata = ASCII_ZERO + {7'd0, desc_q.sensors[0]};
			IDX_W'(3): m_tdata = ASCII_ZERO + {7'd0, desc_q.sensors[1]};
			IDX_W'(4): m_tdata = ASCII_ZERO + {7'd0, desc_q.sensors[2]};
			IDX_W'(5): m_tdata = ASCII_ZERO + {7'd0, desc_q.sensors[3]};
			default:   m_tdata = REPLY_HEAD;
		endcase
	end

	// Advance through the reply; load the next request when idle or at its end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (done) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Hold the request being sent
	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= pop_data;
		end
	end

endmodule

@@ dv/rs485_cell_command_slave_tb.sv @@
// Testbench for rs485_cell_command_slave: directed and random byte streams with frames.
// Depends on rs485ccs_pkg and the block's RTL; predicts replies and checks every byte.
`timescale 1ns / 100ps

module rs485_cell_command_slave_tb;
	import rs485ccs_pkg::*;

	localparam int IDLE_LIMIT   = 3000;
	localparam int SETTLE_TICKS = 16;
	localparam int PRINT_CAP    = 100;

	// One expected reply byte with its side flags
	typedef struct {
		logic [7:0] tx;
		logic       last;
		logic       sol_on;
		logic       fp_start;
	} reply_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;     // rx_byte[7:0], sensor_one, sensor_two,
	                               // sensor_three, sensor_four, 4'b0
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;          // tx_byte[7:0]
	logic        m_tlast;
	logic [1:0]  m_tuser;          // solenoid_on, full_power_start
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;    // cell_address[7:0]

	// Predicted block state
	logic [1:0]  frame_pos = POS_IDLE;
	logic [7:0]  frame_buf [3];
	logic        sol_state = 1'b0;
	logic [7:0]  cell_addr = 8'd0;

	reply_byte_t reply_q [$];
	int          err_count = 0;
	int          rx_count = 0;
	int          idle_ticks = 0;
	bit          idle_on = 1'b0;
	int          stall_left = 0;

	rs485_cell_command_slave DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (err_count < PRINT_CAP)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		err_count++;
	endtask

	// Advance the frame tracker by one received byte; queue the reply of a closing frame
	task automatic track_rx_byte(input logic [7:0] b, input logic [3:0] sens);
		logic [7:0] addr;
		logic       fp;
		reply_byte_t r;
		if (b == NULL_BYTE)
			return;
		if (b == START_BYTE) begin
			frame_pos = POS_DIG1;
			return;
		end
		if (frame_pos == POS_IDLE)
			return;
		frame_buf[frame_pos - 2'd1] = b;
		if (frame_pos != POS_CMD) begin
			frame_pos = frame_pos + 2'd1;
			return;
		end
		frame_pos = POS_IDLE;
		if (frame_buf[0] < ASCII_ZERO || frame_buf[1] < ASCII_ZERO || frame_buf[2] < ASCII_ZERO)
			return;
		addr = (frame_buf[0] - ASCII_ZERO) * ADDR_RADIX + (frame_buf[1] - ASCII_ZERO);
		if (addr != cell_addr)
			return;
		fp = 1'b0;
		if (frame_buf[2] == ASCII_ONE) begin
			if (!sol_state) begin
				sol_state = 1'b1;
				fp = 1'b1;
			end
		end else if (frame_buf[2] == ASCII_ZERO) begin
			sol_state = 1'b0;
		end
		for (int k = 0; k < REPLY_LEN; k++) begin
			case (k)
				0: r.tx = REPLY_HEAD;
				1: r.tx = ASCII_ZERO + {7'd0, sol_state};
				default: r.tx = ASCII_ZERO + {7'd0, sens[k-2]};
			endcase
			r.last     = (k == REPLY_LEN - 1);
			r.sol_on   = sol_state;
			r.fp_start = fp;
			reply_q.push_back(r);
		end
	endtask

	// Present one byte, optionally after an idle burst, and hold it until taken
	task automatic send_byte(input logic [7:0] b, input logic [3:0] sens);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, sens, b};
		do @(posedge clk); while (!s_tready);
		rx_count++;
		track_rx_byte(b, sens);
	endtask

	task automatic send_frame(input logic [7:0] d1, input logic [7:0] d2,
			input logic [7:0] cmd, input logic [3:0] sens);
		send_byte(START_BYTE, sens);
		send_byte(d1, sens);
		send_byte(d2, sens);
		send_byte(cmd, sens);
	endtask

	// Drop the request line and wait until every reply is out and the block is quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic load_cell_address(input logic [7:0] a);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= a;
		do @(posedge clk); while (!cfg_ready);
		cell_addr = a;
		cfg_valid <= 1'b0;
	endtask

	// Pick two digit bytes that decode to the given address
	task automatic digits_for(input logic [7:0] a, output logic [7:0] d1, output logic [7:0] d2);
		logic [7:0] rest;
		if (a < 8'd100 && $urandom_range(0, 1) == 0) begin
			d1 = ASCII_ZERO + a / ADDR_RADIX;
			d2 = ASCII_ZERO + a % ADDR_RADIX;
			return;
		end
		do begin
			d1   = 8'($urandom_range(8'h30, 8'hFF));
			rest = a - (d1 - ASCII_ZERO) * ADDR_RADIX;
		end while (rest > 8'hCF);
		d2 = rest + ASCII_ZERO;
	endtask

	// Send a byte inside a frame, with a stray zero in front now and then
	task automatic send_frame_byte(input logic [7:0] b);
		if ($urandom_range(0, 9) == 0)
			send_byte(NULL_BYTE, 4'($urandom));
		send_byte(b, 4'($urandom));
	endtask

	// Mostly well-formed frames with random content, the rest broken frames and noise
	task automatic run_random_traffic(input int n_items, input bit allow_idle);
		int stop_at;
		int pick;
		logic [7:0] d1, d2, cmd;
		stop_at = rx_count + n_items;
		while (rx_count < stop_at) begin
			idle_on = allow_idle && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if ($urandom_range(0, 9) < 8) begin
					digits_for(cell_addr, d1, d2);
				end else begin
					d1 = 8'($urandom_range(8'h30, 8'hFF));
					d2 = 8'($urandom_range(8'h30, 8'hFF));
				end
				case ($urandom_range(0, 9))
					0, 1, 2, 3: cmd = ASCII_ONE;
					4, 5, 6:    cmd = ASCII_ZERO;
					7, 8:       cmd = 8'($urandom_range(8'h30, 8'hFF));
					default:    cmd = 8'($urandom_range(8'h01, 8'h2F));
				endcase
				send_byte(START_BYTE, 4'($urandom));
				send_frame_byte(d1);
				send_frame_byte(d2);
				send_frame_byte(cmd);
			end else if (pick < 85) begin
				send_byte(START_BYTE, 4'($urandom));
				repeat ($urandom_range(1, 2))
					send_byte(8'($urandom), 4'($urandom));
			end else begin
				send_byte(8'($urandom), 4'($urandom));
			end
		end
	endtask

	// Directed frames: each special case once, with several sensor patterns
	task automatic test_directed_frames();
		idle_on = 1'b1;
		load_cell_address(8'd12);
		send_byte(ASCII_ZERO + 8'd17, 4'b0110);
		send_frame(ASCII_ZERO + 8'd1, ASCII_ZERO + 8'd2, ASCII_ONE, 4'b1111);
		send_byte(START_BYTE, 4'b0000);
		send_byte(ASCII_ZERO + 8'd1, 4'b0000);
		send_byte(NULL_BYTE, 4'b0000);
		send_byte(ASCII_ZERO + 8'd2, 4'b0000);
		send_byte(ASCII_ONE, 4'b0000);
		send_byte(START_BYTE, 4'b0101);
		send_byte(ASCII_ZERO + 8'd1, 4'b0101);
		send_frame(ASCII_ZERO + 8'd1, ASCII_ZERO + 8'd2, 8'hFF, 4'b0101);
		send_frame(ASCII_ZERO + 8'd1, ASCII_ZERO - 8'd1, ASCII_ZERO, 4'b1111);
		send_frame(ASCII_ZERO + 8'd9, ASCII_ZERO + 8'd9, ASCII_ZERO, 4'b1111);
		send_frame(ASCII_ZERO + 8'd1, ASCII_ZERO + 8'd2, ASCII_ZERO, 4'b1010);
		send_byte(NULL_BYTE, 4'b1111);
	endtask

	// Random traffic at the lowest and highest cell address
	task automatic test_address_extremes();
		load_cell_address(8'd0);
		run_random_traffic(50, 1'b1);
		load_cell_address(8'd255);
		run_random_traffic(50, 1'b1);
	endtask

	task automatic test_random_addresses();
		load_cell_address(8'($urandom_range(0, 255)));
		run_random_traffic(50, 1'b1);
		load_cell_address(8'($urandom_range(0, 99)));
		run_random_traffic(50, 1'b1);
	endtask

	// Back-to-back traffic with both sides always ready
	task automatic test_steady_stream();
		idle_on = 1'b0;
		load_cell_address(8'($urandom_range(0, 99)));
		run_random_traffic(60, 1'b0);
	endtask

	// Drive the reply ready with random stall bursts and check each accepted byte
	always @(posedge clk) begin
		reply_byte_t r;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (reply_q.size() == 0) begin
					report_mismatch($sformatf("unexpected reply byte %h", m_tdata));
				end else begin
					r = reply_q.pop_front();
					if (m_tdata !== r.tx)
						report_mismatch($sformatf("tx_byte %h, want %h", m_tdata, r.tx));
					if (m_tlast !== r.last)
						report_mismatch($sformatf("last_byte %b, want %b", m_tlast, r.last));
					if (m_tuser[0] !== r.sol_on)
						report_mismatch($sformatf("solenoid_on %b, want %b",
							m_tuser[0], r.sol_on));
					if (m_tuser[1] !== r.fp_start)
						report_mismatch($sformatf("full_power_start %b, want %b",
							m_tuser[1], r.fp_start));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// End the run when nothing moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_ticks <= 0;
		end else if (idle_ticks >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_ticks <= idle_ticks + 1;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_address_extremes();
		test_random_addresses();
		test_steady_stream();
		settle();
		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/rs485ccs_pkg.sv
sv/rs485ccs_front.sv
sv/rs485ccs_queue.sv
sv/rs485ccs_back.sv
sv/rs485_cell_command_slave.sv
dv/rs485_cell_command_slave_tb.sv
